// ===== rtl/sssat_pkg.sv =====
// Shared types, constants, sine ROM and microcode table for the stereo slew saturator.
package sssat_pkg;

   // Sample and gain formats
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS = SAMPLE_BITS - 1;
   localparam int OUT_BITS = SAMPLE_BITS + 5;
   localparam int GAIN_BITS = 16;
   localparam int BOOST_BITS = 22;
   localparam int LEVEL_BITS = 17;
   localparam int WET_BITS = 17;
   localparam int RATE_BITS = 20;
   localparam int CSR_DATA_BITS = 22;
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [LEVEL_BITS-1:0] GAIN_ONE = 17'd65536;

   // Register indexes on the config port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_GAIN = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_MIX = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_SCALE = 2'd3;

   // Shared multiplier: signed A times unsigned B
   localparam int MUL_A_BITS = OUT_BITS + 1;
   localparam int MUL_B_BITS = 24;
   localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS + 1;
   localparam int WIDE_BITS = PROD_BITS - GAIN_BITS;
   localparam int ACC_BITS = SAMPLE_BITS + WET_BITS;

   // Sine ROM: unsigned Q1.23 entries, sin(pi*k/depth)
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int ROM_BITS = 24;
   localparam int ROM_FRAC = 23;
   localparam int LIM_BITS = ROM_BITS + RATE_BITS - (ROM_FRAC + GAIN_BITS - FRAC_BITS);
   localparam int LIM_SHIFT = ROM_FRAC + GAIN_BITS - FRAC_BITS;
   localparam int PHASE_SHIFT = 24;
   localparam int ROM_IDX_SHIFT = PHASE_SHIFT + FRAC_BITS - IDX_BITS;
   localparam logic [MUL_B_BITS-1:0] PHASE_GAIN = 24'd6710746;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam logic signed [MUL_A_BITS-1:0] UNITY_Q = 30'sd1 <<< FRAC_BITS;
   localparam logic signed [WIDE_BITS-1:0] WIDE_MAX = (39'sd1 <<< (OUT_BITS - 1)) - 39'sd1;
   localparam logic signed [WIDE_BITS-1:0] WIDE_MIN = -(39'sd1 <<< (OUT_BITS - 1));

   typedef logic [ROM_BITS-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // Elaboration-time sine table, 13th-order Taylor series in Q30, folded
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0] kk;
      logic [63:0] ang;
      logic [63:0] ang2;
      logic [63:0] term;
      longint sum;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         kk = (k * 2 > SINE_TABLE_DEPTH) ? 64'(SINE_TABLE_DEPTH - k) : 64'(k);
         ang = (PI_Q30 * kk) / SINE_TABLE_DEPTH;
         ang2 = (ang * ang) >> 30;
         term = ang;
         sum = longint'(ang);
         term = ((term * ang2) >> 30) / 6;
         sum = sum - longint'(term);
         term = ((term * ang2) >> 30) / 20;
         sum = sum + longint'(term);
         term = ((term * ang2) >> 30) / 42;
         sum = sum - longint'(term);
         term = ((term * ang2) >> 30) / 72;
         sum = sum + longint'(term);
         term = ((term * ang2) >> 30) / 110;
         sum = sum - longint'(term);
         term = ((term * ang2) >> 30) / 156;
         sum = sum + longint'(term);
         if (sum < 0) sum = 0;
         sum = (sum + 64) >>> 7;
         if (sum > (longint'(1) << ROM_FRAC)) sum = longint'(1) << ROM_FRAC;
         rom[k] = sum[ROM_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Saturate a wide intermediate to the Q5.23 output range
   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [WIDE_BITS-1:0] v);
      if (v > WIDE_MAX) return WIDE_MAX[OUT_BITS-1:0];
      if (v < WIDE_MIN) return WIDE_MIN[OUT_BITS-1:0];
      return v[OUT_BITS-1:0];
   endfunction

   // Controller state
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Microcode fields
   typedef enum logic [1:0] {
      A_IN,
      A_V,
      A_ROM,
      A_Y
   } a_sel_type;

   typedef enum logic [2:0] {
      B_BOOST,
      B_PHASE,
      B_RATE,
      B_LEVEL,
      B_DRY,
      B_WET
   } b_sel_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SLEWIN,
      OP_ROM,
      OP_SLEW,
      OP_LEVEL,
      OP_ACC,
      OP_MIX,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_LEVEL_OFF,
      JMP_WET_OFF
   } jump_type;

   localparam int STEP_BITS = 4;
   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_DRY = 4'd8;
   localparam step_type STEP_EMIT = 4'd13;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      mul_ch;
      op_type    op;
      logic      op_ch;
      jump_type  jmp;
      step_type  target;
   } ucode_type;

   // Program: left and right interleave on the multiplier, each op
   // consumes the product registered by the step before it.
   function automatic ucode_type ucode(input step_type step);
      ucode_type w;
      w = '{A_IN, B_BOOST, 1'b0, OP_NONE, 1'b0, JMP_NONE, 4'd0};
      case (step)
         4'd0: w = '{A_IN, B_BOOST, 1'b0, OP_NONE, 1'b0, JMP_NONE, 4'd0};
         4'd1: w = '{A_IN, B_BOOST, 1'b1, OP_SLEWIN, 1'b0, JMP_NONE, 4'd0};
         4'd2: w = '{A_V, B_PHASE, 1'b0, OP_SLEWIN, 1'b1, JMP_NONE, 4'd0};
         4'd3: w = '{A_V, B_PHASE, 1'b1, OP_ROM, 1'b0, JMP_NONE, 4'd0};
         4'd4: w = '{A_ROM, B_RATE, 1'b0, OP_ROM, 1'b1, JMP_NONE, 4'd0};
         4'd5: w = '{A_ROM, B_RATE, 1'b1, OP_SLEW, 1'b0, JMP_NONE, 4'd0};
         4'd6: w = '{A_Y, B_LEVEL, 1'b0, OP_SLEW, 1'b1, JMP_LEVEL_OFF, STEP_DRY};
         4'd7: w = '{A_Y, B_LEVEL, 1'b1, OP_LEVEL, 1'b0, JMP_NONE, 4'd0};
         4'd8: w = '{A_IN, B_DRY, 1'b0, OP_LEVEL, 1'b1, JMP_WET_OFF, STEP_EMIT};
         4'd9: w = '{A_IN, B_DRY, 1'b1, OP_ACC, 1'b0, JMP_NONE, 4'd0};
         4'd10: w = '{A_Y, B_WET, 1'b0, OP_ACC, 1'b1, JMP_NONE, 4'd0};
         4'd11: w = '{A_Y, B_WET, 1'b1, OP_MIX, 1'b0, JMP_NONE, 4'd0};
         4'd12: w = '{A_IN, B_BOOST, 1'b0, OP_MIX, 1'b1, JMP_NONE, 4'd0};
         4'd13: w = '{A_IN, B_BOOST, 1'b0, OP_EMIT, 1'b0, JMP_NONE, 4'd0};
         default: w = '{A_IN, B_BOOST, 1'b0, OP_EMIT, 1'b0, JMP_NONE, 4'd0};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/sssat_if.sv =====
// Valid/ready channel interfaces for stereo frames in and out.
interface sssat_req_if;
   logic valid;
   logic ready;
   logic signed [sssat_pkg::SAMPLE_BITS-1:0] sample_left;
   logic signed [sssat_pkg::SAMPLE_BITS-1:0] sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface sssat_rsp_if;
   logic valid;
   logic ready;
   logic signed [sssat_pkg::OUT_BITS-1:0] out_left;
   logic signed [sssat_pkg::OUT_BITS-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/stereo_sine_slew_saturator.sv =====
// Stereo slew-limited saturator: microcoded sequencer over one shared multiplier.
// Program steps are skipped when output_level or wet_mix is at or above unity.
// A new frame is accepted only after the last one is emitted; every step uses the single 30x25 multiplier.
// Synchronous reset clears held outputs to zero and config to defaults; no warm-up.
module stereo_sine_slew_saturator (
   input  logic                                   clock,
   input  logic                                   reset,
   sssat_req_if.sink                              req,
   sssat_rsp_if.source                            rsp,
   input  logic                                   csr_write_en,
   input  logic [sssat_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sssat_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // Config registers
   logic [sssat_pkg::BOOST_BITS-1:0] boost_ff;
   logic [sssat_pkg::LEVEL_BITS-1:0] level_ff;
   logic [sssat_pkg::WET_BITS-1:0]   wet_ff;
   logic [sssat_pkg::RATE_BITS-1:0]  rate_ff;

   // Sequencer
   sssat_pkg::state_type state_ff, state_in;
   sssat_pkg::step_type  step_ff, step_in;
   sssat_pkg::ucode_type uc;
   logic run_en;
   logic emit;
   logic stall;
   logic jump_taken;
   logic accept;
   logic level_active;
   logic wet_active;

   // Per-channel datapath registers and the shared product register
   logic signed [sssat_pkg::SAMPLE_BITS-1:0] in_ff   [2];
   logic signed [sssat_pkg::OUT_BITS-1:0]    last_ff [2];
   logic signed [sssat_pkg::MUL_A_BITS-1:0]  d_ff    [2];
   logic signed [sssat_pkg::MUL_A_BITS-1:0]  v_ff    [2];
   logic [sssat_pkg::ROM_BITS-1:0]           rom_ff  [2];
   logic signed [sssat_pkg::OUT_BITS-1:0]    y_ff    [2];
   logic signed [sssat_pkg::ACC_BITS-1:0]    acc_ff  [2];
   logic signed [sssat_pkg::PROD_BITS-1:0]   prod_ff, prod_in;

   // Result register
   logic                                  rsp_valid_ff;
   logic signed [sssat_pkg::OUT_BITS-1:0] out_left_ff;
   logic signed [sssat_pkg::OUT_BITS-1:0] out_right_ff;

   // Multiplier operands and op results
   logic signed [sssat_pkg::MUL_A_BITS-1:0] mul_a;
   logic [sssat_pkg::MUL_B_BITS-1:0]        mul_b;
   logic [sssat_pkg::WET_BITS-1:0]          dry;
   logic signed [sssat_pkg::OUT_BITS-1:0]   x_val;
   logic signed [sssat_pkg::MUL_A_BITS-1:0] diff;
   logic signed [sssat_pkg::MUL_A_BITS-1:0] v_val;
   logic [sssat_pkg::IDX_BITS-1:0]          idx;
   logic signed [sssat_pkg::MUL_A_BITS-1:0] lim;
   logic signed [sssat_pkg::MUL_A_BITS-1:0] d_lim;
   logic signed [sssat_pkg::OUT_BITS+1:0]   last_sum;
   logic signed [sssat_pkg::OUT_BITS-1:0]   last_new;
   logic signed [sssat_pkg::OUT_BITS-1:0]   y_scaled;
   logic signed [sssat_pkg::PROD_BITS-1:0]  mix_sum;
   logic signed [sssat_pkg::OUT_BITS-1:0]   y_mix;

   assign uc = sssat_pkg::ucode(step_ff);
   assign level_active = level_ff < sssat_pkg::GAIN_ONE;
   assign wet_active = wet_ff < sssat_pkg::GAIN_ONE;
   assign dry = sssat_pkg::GAIN_ONE - wet_ff;

   assign req.ready = (state_ff == sssat_pkg::ST_IDLE);
   assign accept = req.valid && req.ready;
   assign stall = (uc.op == sssat_pkg::OP_EMIT) && rsp_valid_ff && !rsp.ready;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_left = out_left_ff;
   assign rsp.out_right = out_right_ff;

   // Jump decode
   always_comb begin
      case (uc.jmp)
         sssat_pkg::JMP_LEVEL_OFF: jump_taken = !level_active;
         sssat_pkg::JMP_WET_OFF:   jump_taken = !wet_active;
         default:                  jump_taken = 1'b0;
      endcase
   end

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      run_en = 1'b0;
      emit = 1'b0;
      case (state_ff)
         sssat_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sssat_pkg::ST_RUN;
               step_in = '0;
            end
         end
         sssat_pkg::ST_RUN: begin
            if (!stall) begin
               run_en = 1'b1;
               if (uc.op == sssat_pkg::OP_EMIT) begin
                  emit = 1'b1;
                  state_in = sssat_pkg::ST_IDLE;
               end else if (jump_taken) begin
                  step_in = uc.target;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = sssat_pkg::ST_IDLE;
      endcase
   end

   // Shared multiplier operand select
   always_comb begin
      case (uc.a_sel)
         sssat_pkg::A_IN:  mul_a = sssat_pkg::MUL_A_BITS'(in_ff[uc.mul_ch]);
         sssat_pkg::A_V:   mul_a = v_ff[uc.mul_ch];
         sssat_pkg::A_ROM: mul_a = $signed(sssat_pkg::MUL_A_BITS'(rom_ff[uc.mul_ch]));
         sssat_pkg::A_Y:   mul_a = sssat_pkg::MUL_A_BITS'(y_ff[uc.mul_ch]);
         default:          mul_a = '0;
      endcase
      case (uc.b_sel)
         sssat_pkg::B_BOOST: mul_b = sssat_pkg::MUL_B_BITS'(boost_ff);
         sssat_pkg::B_PHASE: mul_b = sssat_pkg::PHASE_GAIN;
         sssat_pkg::B_RATE:  mul_b = sssat_pkg::MUL_B_BITS'(rate_ff);
         sssat_pkg::B_LEVEL: mul_b = sssat_pkg::MUL_B_BITS'(level_ff);
         sssat_pkg::B_DRY:   mul_b = sssat_pkg::MUL_B_BITS'(dry);
         sssat_pkg::B_WET:   mul_b = sssat_pkg::MUL_B_BITS'(wet_ff);
         default:            mul_b = '0;
      endcase
      prod_in = mul_a * $signed({1'b0, mul_b});
   end

   // Op datapath: everything reads prod_ff from the previous step
   always_comb begin
      // boosted sample, distance to last output, limit argument
      x_val = sssat_pkg::sat_out(prod_ff[sssat_pkg::PROD_BITS-1:sssat_pkg::GAIN_BITS]);
      diff = sssat_pkg::MUL_A_BITS'(x_val) - sssat_pkg::MUL_A_BITS'(last_ff[uc.op_ch]);
      if (diff > 0) v_val = sssat_pkg::UNITY_Q - sssat_pkg::MUL_A_BITS'(x_val);
      else v_val = sssat_pkg::MUL_A_BITS'(x_val) + sssat_pkg::UNITY_Q;

      // sine index, clamped to the last entry; non-positive argument reads entry zero
      if (v_ff[uc.op_ch] <= 0) begin
         idx = '0;
      end else if (|prod_ff[sssat_pkg::PROD_BITS-1:sssat_pkg::ROM_IDX_SHIFT+sssat_pkg::IDX_BITS])
      begin
         idx = '1;
      end else begin
         idx = prod_ff[sssat_pkg::ROM_IDX_SHIFT+sssat_pkg::IDX_BITS-1:sssat_pkg::ROM_IDX_SHIFT];
      end

      // slew clamp and new held value
      lim = $signed(sssat_pkg::MUL_A_BITS'(
         prod_ff[sssat_pkg::LIM_SHIFT+sssat_pkg::LIM_BITS-1:sssat_pkg::LIM_SHIFT]));
      d_lim = d_ff[uc.op_ch];
      if (d_ff[uc.op_ch] > 0 && d_ff[uc.op_ch] > lim) d_lim = lim;
      else if (d_ff[uc.op_ch] < 0 && d_ff[uc.op_ch] < -lim) d_lim = -lim;
      last_sum = (sssat_pkg::OUT_BITS+2)'(last_ff[uc.op_ch]) + (sssat_pkg::OUT_BITS+2)'(d_lim);
      last_new = sssat_pkg::sat_out(sssat_pkg::WIDE_BITS'(last_sum));

      // output level and wet/dry blend
      y_scaled = sssat_pkg::sat_out(prod_ff[sssat_pkg::PROD_BITS-1:sssat_pkg::GAIN_BITS]);
      mix_sum = prod_ff + sssat_pkg::PROD_BITS'(acc_ff[uc.op_ch]);
      y_mix = sssat_pkg::sat_out(mix_sum[sssat_pkg::PROD_BITS-1:sssat_pkg::GAIN_BITS]);
   end

   // Control state and config
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sssat_pkg::ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
         boost_ff <= 22'd65536;
         level_ff <= 17'd65536;
         wet_ff <= 17'd65536;
         rate_ff <= 20'd65536;
         last_ff[0] <= '0;
         last_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_write_en) begin
            case (csr_index)
               sssat_pkg::CSR_BOOST_GAIN:   boost_ff <= csr_wdata[sssat_pkg::BOOST_BITS-1:0];
               sssat_pkg::CSR_OUTPUT_LEVEL: level_ff <= csr_wdata[sssat_pkg::LEVEL_BITS-1:0];
               sssat_pkg::CSR_WET_MIX:      wet_ff <= csr_wdata[sssat_pkg::WET_BITS-1:0];
               sssat_pkg::CSR_RATE_SCALE:   rate_ff <= csr_wdata[sssat_pkg::RATE_BITS-1:0];
               default: ;
            endcase
         end
         if (run_en && uc.op == sssat_pkg::OP_SLEW) last_ff[uc.op_ch] <= last_new;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         in_ff[0] <= req.sample_left;
         in_ff[1] <= req.sample_right;
      end
      if (run_en) begin
         case (uc.op)
            sssat_pkg::OP_SLEWIN: begin
               d_ff[uc.op_ch] <= diff;
               v_ff[uc.op_ch] <= v_val;
            end
            sssat_pkg::OP_ROM:   rom_ff[uc.op_ch] <= sssat_pkg::SINE_ROM[idx];
            sssat_pkg::OP_SLEW:  y_ff[uc.op_ch] <= last_new;
            sssat_pkg::OP_LEVEL: if (level_active) y_ff[uc.op_ch] <= y_scaled;
            sssat_pkg::OP_ACC:   acc_ff[uc.op_ch] <= prod_ff[sssat_pkg::ACC_BITS-1:0];
            sssat_pkg::OP_MIX:   if (wet_active) y_ff[uc.op_ch] <= y_mix;
            sssat_pkg::OP_EMIT: begin
               out_left_ff <= y_ff[0];
               out_right_ff <= y_ff[1];
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/sssat_checker.sv =====
// Port-level checks for the stereo slew saturator, bound to the top level.
module sssat_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [sssat_pkg::OUT_BITS-1:0]      out_left,
   input logic [sssat_pkg::OUT_BITS-1:0]      out_right
);

   logic [1:0] pending_ff, pending_in;

   // Frames accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) pending_in = pending_in + 2'd1;
      if (rsp_valid && rsp_ready) pending_in = pending_in - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pending_ff <= '0;
      else pending_ff <= pending_in;
   end

   // A stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // A stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_left) && $stable(out_right))
      else $error("rsp payload changed while stalled");

   // Work on an accepted frame blocks the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted again while a frame is in work");

   // No result without a frame behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("rsp beat without an accepted req beat");

   // At most one waiting result when a new frame comes in
   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> pending_ff == 2'd0 || pending_ff == 2'd1)
      else $error("frame accepted with too many outstanding");

endmodule

bind stereo_sine_slew_saturator sssat_checker u_sssat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .out_left  (rsp.out_left),
   .out_right (rsp.out_right)
);
